// ===== src/rau_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the rational arithmetic unit.
// Used by rau_mul, rau_div and rational_arithmetic_unit; depends on nothing.
package rau_pkg;

  // result word width; a reduced result must fit a signed word of this size
  localparam int WORD_BITS = 32;
  localparam int PROD_BITS = 64;
  localparam logic [PROD_BITS-1:0] RES_LIM = (PROD_BITS'(1) << (WORD_BITS - 1)) - PROD_BITS'(1);

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_Q,
    S_MUL_D,
    S_MUL_N,
    S_EVAL,
    S_GCD,
    S_GCD_SH,
    S_DIV_M,
    S_DIV_D,
    S_DONE
  } state_t;

endpackage

// ===== src/rau_mul.sv =====
`timescale 1ns / 1ps
// Bit-serial 32 x 32 unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on rau_pkg.
module rau_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [31:0]                   mcand,
  input  logic [31:0]                   mplier,
  output logic                          done,
  output logic [rau_pkg::PROD_BITS-1:0] prod
);

  logic [rau_pkg::PROD_BITS-1:0] acc_r;
  logic [rau_pkg::PROD_BITS-1:0] mc_r;
  logic [31:0]                   mp_r;
  logic [4:0]                    cnt_r;
  logic                          busy_r;
  logic                          done_r;

  // control: run 32 steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: add shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      mc_r  <= {{(rau_pkg::PROD_BITS-32){1'b0}}, mcand};
      mp_r  <= mplier;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r <= mc_r << 1;
      mp_r <= mp_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== src/rau_div.sv =====
`timescale 1ns / 1ps
// Restoring 64 / 64 unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg.
module rau_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rau_pkg::PROD_BITS-1:0] dividend,
  input  logic [rau_pkg::PROD_BITS-1:0] divisor,
  output logic                          done,
  output logic [rau_pkg::PROD_BITS-1:0] quotient
);

  logic [rau_pkg::PROD_BITS-1:0] rem_r;
  logic [rau_pkg::PROD_BITS-1:0] quo_r;
  logic [rau_pkg::PROD_BITS-1:0] dvs_r;
  logic [5:0]                    cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [rau_pkg::PROD_BITS:0]   trial;
  logic                          fits;

  // shift in next dividend bit and test against the divisor
  assign trial = {rem_r, quo_r[rau_pkg::PROD_BITS-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rau_pkg::PROD_BITS'(trial - {1'b0, dvs_r});
      end else begin
        rem_r <= trial[rau_pkg::PROD_BITS-1:0];
      end
      quo_r <= {quo_r[rau_pkg::PROD_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Rational ALU: add, subtract, multiply or divide two fractions, reduced by gcd.
// Uses rau_pkg, the serial multiplier rau_mul and the serial divider rau_div.
//
// One transaction is taken at a time. Cross products are formed by a shared
// bit-serial multiplier (two products for divide, three for add and subtract,
// four for multiply), the gcd by a binary gcd that takes one shift or subtract
// per cycle on 64-bit magnitudes, followed by restoring the common power of
// two, and both reducing divisions by a restoring divider. Zero-denominator
// items skip all arithmetic, and divide-by-zero items end after the two cross
// products.
// The result sits in an output register, so a new transaction is accepted
// while a finished one waits to be taken. Status 1 flags division by zero,
// status 2 a reduced result that does not fit; both return 0/1.
module rational_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_a_num,
  input  logic [30:0] in_a_den,
  input  logic [31:0] in_b_num,
  input  logic [30:0] in_b_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_res_num,
  output logic [30:0] out_res_den,
  output logic [1:0]  out_status,
  output logic        out_a_less,
  output logic        out_a_equal,
  output logic        out_a_greater
);

  localparam int PB = rau_pkg::PROD_BITS;

  rau_pkg::state_t state_r, state_nxt;

  // captured operands
  logic [1:0]  cmd_r;
  logic [31:0] an_r, bn_r;
  logic [30:0] ad_r, bd_r;

  // working values
  logic signed [PB-1:0] p_r, q_r, n_r, d_r;
  logic [PB-1:0]        x_r, y_r, m_r, ud_r;
  logic [5:0]           k_r;
  logic                 neg_r;
  logic [1:0]           st_r;
  logic                 cmp_ok_r;
  logic                 launch_r;

  // output register
  logic        out_valid_r;
  logic [31:0] out_num_r;
  logic [30:0] out_den_r;
  logic [1:0]  out_st_r;
  logic        out_lt_r, out_eq_r, out_gt_r;

  // multiplier and divider hookup
  logic          mul_start, mul_done;
  logic [31:0]   mul_a, mul_b;
  logic [PB-1:0] mul_prod;
  logic          div_start, div_done;
  logic [PB-1:0] div_a, div_q;

  logic [31:0]   an_mag, bn_mag;
  logic          in_acc, out_load;
  logic [PB-1:0] n_mag, d_mag;
  logic          ovf;
  logic          gcd_end;

  assign an_mag = an_r[31] ? 32'(-an_r) : an_r;
  assign bn_mag = bn_r[31] ? 32'(-bn_r) : bn_r;
  assign n_mag  = n_r[PB-1] ? PB'(-n_r) : PB'(n_r);
  assign d_mag  = d_r[PB-1] ? PB'(-d_r) : PB'(d_r);
  assign gcd_end = x_r[0] && y_r[0] && (x_r == y_r);

  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == rau_pkg::S_DONE) && (!out_valid_r || out_ready);

  // reduced result must fit the signed word
  assign ovf = (st_r == rau_pkg::ST_OK) &&
               ((ud_r > rau_pkg::RES_LIM) || (m_r > rau_pkg::RES_LIM + PB'(neg_r)));

  rau_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (mul_b),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (x_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rau_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_a_den == '0 || in_b_den == '0) begin
            state_nxt = rau_pkg::S_DONE;
          end else begin
            state_nxt = rau_pkg::S_MUL_P;
          end
        end
      end
      rau_pkg::S_MUL_P: if (mul_done) state_nxt = rau_pkg::S_MUL_Q;
      rau_pkg::S_MUL_Q: begin
        if (mul_done) begin
          if (cmd_r == rau_pkg::CMD_DIV) begin
            state_nxt = (bn_r == '0) ? rau_pkg::S_DONE : rau_pkg::S_EVAL;
          end else begin
            state_nxt = rau_pkg::S_MUL_D;
          end
        end
      end
      rau_pkg::S_MUL_D: begin
        if (mul_done) begin
          state_nxt = (cmd_r == rau_pkg::CMD_MUL) ? rau_pkg::S_MUL_N : rau_pkg::S_EVAL;
        end
      end
      rau_pkg::S_MUL_N: if (mul_done) state_nxt = rau_pkg::S_EVAL;
      rau_pkg::S_EVAL: state_nxt = (n_mag == '0) ? rau_pkg::S_DONE : rau_pkg::S_GCD;
      rau_pkg::S_GCD: if (gcd_end) state_nxt = rau_pkg::S_GCD_SH;
      rau_pkg::S_GCD_SH: if (k_r == '0) state_nxt = rau_pkg::S_DIV_M;
      rau_pkg::S_DIV_M: if (div_done) state_nxt = rau_pkg::S_DIV_D;
      rau_pkg::S_DIV_D: if (div_done) state_nxt = rau_pkg::S_DONE;
      rau_pkg::S_DONE: if (out_load) state_nxt = rau_pkg::S_IDLE;
      default: state_nxt = rau_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer: unit starts and operand selection
  always_comb begin
    in_ready  = (state_r == rau_pkg::S_IDLE);
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = {1'b0, ad_r};
    mul_b     = {1'b0, bd_r};
    div_a     = m_r;
    case (state_r)
      rau_pkg::S_MUL_P: begin
        mul_start = launch_r;
        mul_a     = an_mag;
        mul_b     = {1'b0, bd_r};
      end
      rau_pkg::S_MUL_Q: begin
        mul_start = launch_r;
        mul_a     = bn_mag;
        mul_b     = {1'b0, ad_r};
      end
      rau_pkg::S_MUL_D: mul_start = launch_r;
      rau_pkg::S_MUL_N: begin
        mul_start = launch_r;
        mul_a     = an_mag;
        mul_b     = bn_mag;
      end
      rau_pkg::S_DIV_M: div_start = launch_r;
      rau_pkg::S_DIV_D: begin
        div_start = launch_r;
        div_a     = ud_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rau_pkg::S_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= (state_nxt != state_r);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      rau_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_r    <= in_cmd;
          an_r     <= in_a_num;
          ad_r     <= in_a_den;
          bn_r     <= in_b_num;
          bd_r     <= in_b_den;
          m_r      <= '0;
          ud_r     <= PB'(1);
          neg_r    <= 1'b0;
          cmp_ok_r <= (in_a_den != '0) && (in_b_den != '0);
          st_r     <= (in_a_den == '0 || in_b_den == '0) ? rau_pkg::ST_DIVZ : rau_pkg::ST_OK;
          p_r      <= '0;
          q_r      <= '0;
        end
      end
      rau_pkg::S_MUL_P: begin
        if (mul_done) p_r <= an_r[31] ? -$signed(mul_prod) : $signed(mul_prod);
      end
      rau_pkg::S_MUL_Q: begin
        if (mul_done) begin
          q_r <= bn_r[31] ? -$signed(mul_prod) : $signed(mul_prod);
          n_r <= p_r;
          d_r <= bn_r[31] ? -$signed(mul_prod) : $signed(mul_prod);
          if (cmd_r == rau_pkg::CMD_DIV && bn_r == '0) st_r <= rau_pkg::ST_DIVZ;
        end
      end
      rau_pkg::S_MUL_D: begin
        if (mul_done) begin
          d_r <= $signed(mul_prod);
          n_r <= (cmd_r == rau_pkg::CMD_SUB) ? p_r - q_r : p_r + q_r;
        end
      end
      rau_pkg::S_MUL_N: begin
        if (mul_done) begin
          n_r <= (an_r[31] ^ bn_r[31]) ? -$signed(mul_prod) : $signed(mul_prod);
        end
      end
      rau_pkg::S_EVAL: begin
        if (n_mag != '0) begin
          neg_r <= n_r[PB-1] ^ d_r[PB-1];
          m_r   <= n_mag;
          ud_r  <= d_mag;
        end
        x_r <= n_mag;
        y_r <= d_mag;
        k_r <= '0;
      end
      rau_pkg::S_GCD: begin
        // binary gcd step: strip common twos, halve an even operand, else odd-odd subtract
        if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 6'd1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r > y_r) begin
          x_r <= x_r - y_r;
        end else if (y_r > x_r) begin
          y_r <= y_r - x_r;
        end
      end
      rau_pkg::S_GCD_SH: begin
        if (k_r != '0) begin
          x_r <= x_r << 1;
          k_r <= k_r - 6'd1;
        end
      end
      rau_pkg::S_DIV_M: if (div_done) m_r <= div_q;
      rau_pkg::S_DIV_D: if (div_done) ud_r <= div_q;
      default: ;
    endcase
  end

  // load the output register from the finished transaction
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (ovf) begin
        out_num_r <= '0;
        out_den_r <= 31'd1;
        out_st_r  <= rau_pkg::ST_OVF;
      end else begin
        out_num_r <= neg_r ? 32'(-m_r[31:0]) : m_r[31:0];
        out_den_r <= ud_r[30:0];
        out_st_r  <= st_r;
      end
      out_lt_r <= cmp_ok_r && (p_r < q_r);
      out_eq_r <= cmp_ok_r && (p_r == q_r);
      out_gt_r <= cmp_ok_r && (p_r > q_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_res_num   = out_num_r;
  assign out_res_den   = out_den_r;
  assign out_status    = out_st_r;
  assign out_a_less    = out_lt_r;
  assign out_a_equal   = out_eq_r;
  assign out_a_greater = out_gt_r;

  // multiplier results arrive only while a product is awaited
  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == rau_pkg::S_MUL_P || state_r == rau_pkg::S_MUL_Q ||
                  state_r == rau_pkg::S_MUL_D || state_r == rau_pkg::S_MUL_N))
    else $error("multiplier done outside a multiply state");

  // divider results arrive only while a reduction is awaited
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == rau_pkg::S_DIV_M || state_r == rau_pkg::S_DIV_D))
    else $error("divider done outside a divide state");

  // compare flags are mutually exclusive
  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_lt_r, out_eq_r, out_gt_r}))
    else $error("more than one compare flag set");

  // any error status carries the result 0/1
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != rau_pkg::ST_OK) |-> (out_num_r == '0 && out_den_r == 31'd1))
    else $error("error status without 0/1 result");

  // gcd never sees a zero operand
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rau_pkg::S_GCD) |-> (x_r != '0 && y_r != '0))
    else $error("zero operand in gcd");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rational_arithmetic_unit: directed and random fraction arithmetic.
// Depends on rau_pkg and the RTL; predicts every result and checks it in order.
module tb;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int TAIL_CYCLES  = 700;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  st;
    logic        lt;
    logic        eq;
    logic        gt;
  } ratio_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = rau_pkg::CMD_ADD;
  logic [31:0] in_a_num = '0;
  logic [30:0] in_a_den = 31'd1;
  logic [31:0] in_b_num = '0;
  logic [30:0] in_b_den = 31'd1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_res_num;
  logic [30:0] out_res_den;
  logic [1:0]  out_status;
  logic        out_a_less;
  logic        out_a_equal;
  logic        out_a_greater;

  ratio_res_t expected_ratios[$];
  int         fail_count = 0;
  int         cycle_count = 0;
  logic       hold_req = 1'b0;

  rational_arithmetic_unit DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Exact rational result of one transaction
  function automatic ratio_res_t predict_ratio(logic [1:0] c, logic [31:0] an_i,
                                               logic [30:0] ad_i, logic [31:0] bn_i,
                                               logic [30:0] bd_i);
    longint an, ad, bn, bd, p, q, n, d;
    longint unsigned m, ud, x, y, r, lim;
    logic neg;
    ratio_res_t o;
    o = '{num: '0, den: 31'd1, st: rau_pkg::ST_DIVZ, lt: 1'b0, eq: 1'b0, gt: 1'b0};
    an = $signed(an_i);
    bn = $signed(bn_i);
    ad = ad_i;
    bd = bd_i;
    if (ad == 0 || bd == 0) return o;
    p = an * bd;
    q = bn * ad;
    o.lt = p < q;
    o.eq = p == q;
    o.gt = p > q;
    case (c)
      rau_pkg::CMD_ADD: begin n = p + q; d = ad * bd; end
      rau_pkg::CMD_SUB: begin n = p - q; d = ad * bd; end
      rau_pkg::CMD_MUL: begin n = an * bn; d = ad * bd; end
      default: begin
        if (bn == 0) return o;
        n = an * bd;
        d = ad * bn;
      end
    endcase
    neg = (n < 0) != (d < 0);
    m = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    o.st = rau_pkg::ST_OK;
    if (m == 0) return o;
    x = m;
    y = ud;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    m = m / x;
    ud = ud / x;
    lim = (64'd1 << (rau_pkg::WORD_BITS - 1)) - 64'd1;
    if (ud > lim || m > lim + (neg ? 64'd1 : 64'd0)) begin
      o.st = rau_pkg::ST_OVF;
      return o;
    end
    o.num = neg ? 32'(-m) : 32'(m);
    o.den = ud[30:0];
    return o;
  endfunction

  // Record a prediction for each accepted transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      expected_ratios.push_back(predict_ratio(in_cmd, in_a_num, in_a_den, in_b_num, in_b_den));
  end

  // Compare each delivered result with the oldest prediction
  always @(posedge clk) begin
    ratio_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_ratios.size() == 0) begin
        $error("result with no pending transaction: %0d/%0d", $signed(out_res_num),
               out_res_den);
        fail_count++;
      end else begin
        e = expected_ratios.pop_front();
        if (out_res_num !== e.num) begin
          $error("res_num expected %0d actual %0d", $signed(e.num), $signed(out_res_num));
          fail_count++;
        end
        if (out_res_den !== e.den) begin
          $error("res_den expected %0d actual %0d", e.den, out_res_den);
          fail_count++;
        end
        if (out_status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, out_status);
          fail_count++;
        end
        if (out_a_less !== e.lt) begin
          $error("a_less expected %0b actual %0b", e.lt, out_a_less);
          fail_count++;
        end
        if (out_a_equal !== e.eq) begin
          $error("a_equal expected %0b actual %0b", e.eq, out_a_equal);
          fail_count++;
        end
        if (out_a_greater !== e.gt) begin
          $error("a_greater expected %0b actual %0b", e.gt, out_a_greater);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: segments of no, light and heavy stalling, plus a long hold on request
  initial begin
    int seg_left;
    int mode;
    int hold_left;
    logic hold_taken;
    seg_left = 0;
    mode = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (seg_left == 0) begin
        mode = $urandom_range(0, 2);
        seg_left = $urandom_range(50, 500);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one transaction; returns at the falling edge after acceptance, valid still high
  task automatic send_ratio(logic [1:0] c, logic [31:0] an, logic [30:0] ad,
                            logic [31:0] bn, logic [30:0] bd);
    in_valid <= 1'b1;
    in_cmd   <= c;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and idle; n sets the length of the pause
  task automatic pause_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (expected_ratios.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_num();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3, 4: return 32'($signed($urandom_range(0, 200)) - 100);
      5, 6: return 32'($signed($urandom_range(0, 200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(0, 19))
      0: return 31'd0;
      1, 2: return 31'h7FFF_FFFF;
      3, 4: return 31'd1;
      5, 6, 7: return 31'($urandom_range(1, 100));
      8, 9: return 31'($urandom_range(1, 100000));
      default: return 31'($urandom_range(1, 32'h7FFF_FFFF));
    endcase
  endfunction

  task automatic send_random_ratio();
    send_ratio(2'($urandom), pick_num(), pick_den(), pick_num(), pick_den());
  endtask

  // Extremes, every operation and the special cases
  task automatic test_directed();
    send_ratio(rau_pkg::CMD_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
    send_ratio(rau_pkg::CMD_SUB, 32'd1, 31'd2, 32'd1, 31'd3);
    send_ratio(rau_pkg::CMD_MUL, -32'sd3, 31'd4, 32'd2, 31'd9);
    send_ratio(rau_pkg::CMD_DIV, 32'd3, 31'd4, -32'sd9, 31'd2);
    send_ratio(rau_pkg::CMD_DIV, 32'd5, 31'd7, 32'd0, 31'd3);           // divide by zero
    send_ratio(rau_pkg::CMD_SUB, 32'd5, 31'd7, 32'd10, 31'd14);         // zero result
    send_ratio(rau_pkg::CMD_ADD, 32'd6, 31'd4, 32'd9, 31'd6);           // unreduced operands
    send_ratio(rau_pkg::CMD_MUL, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1);   // overflow
    send_ratio(rau_pkg::CMD_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
    send_ratio(rau_pkg::CMD_ADD, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
    send_ratio(rau_pkg::CMD_SUB, 32'h8000_0000, 31'd1, 32'h7FFF_FFFF, 31'd1);
    send_ratio(rau_pkg::CMD_DIV, 32'h8000_0000, 31'd1, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_ratio(rau_pkg::CMD_DIV, 32'h8000_0000, 31'd1, -32'sd1, 31'd1); // negation overflow
    send_ratio(rau_pkg::CMD_MUL, 32'h8000_0000, 31'd1, 32'd1, 31'd1);
    send_ratio(rau_pkg::CMD_ADD, 32'd1, 31'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFE);
    send_ratio(rau_pkg::CMD_SUB, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_ratio(rau_pkg::CMD_ADD, 32'd1, 31'd0, 32'd1, 31'd1);           // zero denominators
    send_ratio(rau_pkg::CMD_DIV, 32'd1, 31'd1, 32'd0, 31'd0);
    send_ratio(rau_pkg::CMD_MUL, 32'd0, 31'd0, 32'd0, 31'd5);
    send_ratio(rau_pkg::CMD_ADD, 32'd0, 31'd1, 32'd0, 31'h7FFF_FFFF);
    send_ratio(rau_pkg::CMD_DIV, -32'sd7, 31'd3, -32'sd7, 31'd3);
    send_ratio(rau_pkg::CMD_MUL, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    pause_sender(0);
  endtask

  // Random traffic in bursts with random gaps
  task automatic test_random_bursts(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send_random_ratio();
        sent++;
      end
      if ($urandom_range(0, 2) == 0) pause_sender(0);
      else pause_sender($urandom_range(1, 400));
    end
    pause_sender(0);
  endtask

  // Long receiver hold while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (15) send_random_ratio();
    pause_sender(0);
  endtask

  // Sender pauses until every result is in, then resumes
  task automatic test_drain_restart();
    wait_drained();
    repeat (10) send_random_ratio();
    pause_sender(0);
    wait_drained();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_drain_restart();
    test_backpressure();
    test_random_bursts(1500);
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_ratios.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
